// File: design/mtf_pkg.sv
// Shared types and constants for the move-to-front codec.
`default_nettype none
package mtf_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned OP_W   = 2;
   // Wide enough to compare a list position, a step count or a byte without loss.
   localparam int unsigned CMP_W  = DATA_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_CODE   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE
   } state_type;

   // Broadcast from the sequencer to every cell of the list.
   typedef struct packed {
      logic              shift;
      logic              append;
      logic [DATA_W-1:0] wdata;
      logic [DATA_W-1:0] feed;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: design/mtf_if.sv
// Valid/ready channel interfaces for requests, results and the mode register.
`default_nettype none
interface mtf_req_if import mtf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [DATA_W-1:0] value;
   logic              last;

   modport source (output valid, op, value, last, input ready);
   modport sink   (input valid, op, value, last, output ready);
endinterface

interface mtf_rsp_if import mtf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] code_out;
   logic              error;
   logic              end_mark;

   modport source (output valid, code_out, error, end_mark, input ready);
   modport sink   (input valid, code_out, error, end_mark, output ready);
endinterface

interface mtf_csr_if;
   logic valid;
   logic ready;
   logic mode;

   modport source (output valid, mode, input ready);
   modport sink   (input valid, mode, output ready);
endinterface
`default_nettype wire

// File: design/mtf_cell.sv
// One list entry: shifts toward the head, takes the tail feed, or takes an append.
`default_nettype none
module mtf_cell import mtf_pkg::*; #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned INDEX = 0,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [CNT_W-1:0]  count,
   input  wire logic [DATA_W-1:0] right_in,
   output logic [DATA_W-1:0]      value_out
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              is_tail;

   // Ring closes at the last occupied entry.
   assign is_tail = (count == CNT_W'(INDEX + 1));

   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = is_tail ? ctl.feed : right_in;
      end else if (ctl.append && (count == CNT_W'(INDEX))) begin
         value_in = ctl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule
`default_nettype wire

// File: design/mtf_ctrl.sv
// Sequencer: handles requests, walks the list through the head cell, drives results.
`default_nettype none
module mtf_ctrl import mtf_pkg::*; #(
   parameter int unsigned LIST_DEPTH = 256,
   localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1),
   localparam int unsigned IDX_W = $clog2(LIST_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   mtf_req_if.sink                req_chan,
   mtf_rsp_if.source              rsp_chan,
   mtf_csr_if.sink                csr_chan,
   input  wire logic [DATA_W-1:0] head,
   output cell_ctl_type           ctl,
   output logic [CNT_W-1:0]       count
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              mode_ff, mode_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic              last_ff, last_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] sym_ff, sym_in;
   logic [DATA_W-1:0] hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] code_ff, code_in;
   logic              err_ff, err_in;
   logic              end_ff, end_in;
   logic              out_free;
   logic              match;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Decode matches on position, encode on byte; first hit wins.
   assign match = mode_ff ? (CMP_W'(step_ff) == CMP_W'(key_ff)) : (head == key_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      sym_in       = sym_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      code_in      = code_ff;
      err_in       = err_ff;
      end_in       = end_ff;
      ctl          = '0;
      ctl.feed     = head;

      if (csr_chan.valid) begin
         mode_in = csr_chan.mode;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               unique case (op_type'(req_chan.op))
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(LIST_DEPTH)) begin
                        ctl.append = 1'b1;
                        ctl.wdata  = req_chan.value;
                        count_in   = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  OP_CODE: begin
                     key_in   = req_chan.value;
                     last_in  = req_chan.last;
                     step_in  = '0;
                     found_in = 1'b0;
                     state_in = ST_SEARCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // One full rotation of the occupied entries leaves the list as it was.
            if (step_ff == count_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  code_in      = found_ff ? (mode_ff ? sym_ff : DATA_W'(pos_ff)) : '0;
                  err_in       = !found_ff;
                  end_in       = last_ff;
                  step_in      = '0;
                  state_in     = found_ff ? ST_MOVE : ST_IDLE;
               end
            end else begin
               ctl.shift = 1'b1;
               if (match && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = step_ff[IDX_W-1:0];
                  sym_in   = head;
               end
               step_in = CNT_W'(step_ff + 1'b1);
            end
         end
         ST_MOVE: begin
            // Second rotation: symbol first, entries ahead of it delayed one slot,
            // the old copy dropped, the rest passed through.
            ctl.shift = 1'b1;
            if (step_ff == '0) begin
               ctl.feed = sym_ff;
               hold_in  = head;
            end else if (CMP_W'(step_ff) <= CMP_W'(pos_ff)) begin
               ctl.feed = hold_ff;
               hold_in  = head;
            end
            step_in = CNT_W'(step_ff + 1'b1);
            if (CNT_W'(step_ff + 1'b1) == count_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      key_ff   <= key_in;
      last_ff  <= last_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      sym_ff   <= sym_in;
      hold_ff  <= hold_in;
      code_ff  <= code_in;
      err_ff   <= err_in;
      end_ff   <= end_in;
   end

   // No transfer is taken while reset is held.
   assign req_chan.ready    = (state_ff == ST_IDLE) && !reset;
   assign csr_chan.ready    = !reset;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.code_out = code_ff;
   assign rsp_chan.error    = err_ff;
   assign rsp_chan.end_mark = end_ff;
   assign count             = count_ff;

endmodule
`default_nettype wire

// File: design/move_to_front_codec.sv
// Move-to-front codec top level: sequencer plus the chain of list cells.
//
// The list lives in a chain of LIST_DEPTH cells that rotate toward cell 0, so
// the sequencer only ever looks at the head cell. Clear, and append when the
// list is not full, are applied as they are accepted. A code item is accepted
// in the idle state, then rotates the occupied entries once past the head
// (search) and loads the result register, which waits while the previous
// result is still unread. If the symbol or position is found, a second
// rotation rebuilds the list with the symbol in front. Each rotation covers
// the count occupied entries, count being the current list size. No new
// request is taken until the code item is done, output stall included.
// Write the mode register only while no code item is in progress; it applies
// to the code items that follow.
`default_nettype none
module move_to_front_codec import mtf_pkg::*; #(
   parameter int unsigned LIST_DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   mtf_req_if.sink   req_chan,
   mtf_rsp_if.source rsp_chan,
   mtf_csr_if.sink   csr_chan
);

   localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

   cell_ctl_type      ctl;
   logic [CNT_W-1:0]  count;
   logic [DATA_W-1:0] entry [LIST_DEPTH];

   mtf_ctrl #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .head     (entry[0]),
      .ctl      (ctl),
      .count    (count)
   );

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] right;

      if (i == LIST_DEPTH - 1) begin : g_end
         assign right = ctl.feed;
      end else begin : g_mid
         assign right = entry[i+1];
      end

      mtf_cell #(
         .DEPTH (LIST_DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count),
         .right_in  (right),
         .value_out (entry[i])
      );
   end

endmodule
`default_nettype wire
